[hw/rtl/stp_pkg.sv]
// Shared types and constants for the swing peak / trough detector.
`default_nettype none

package stp_pkg;

    localparam int PRICE_BITS = 32;
    localparam int LAG_BITS   = 16;

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [LAG_BITS-1:0]   lag_t;

    typedef enum logic [2:0] {
        PH_PRIME,
        PH_START,
        PH_SEEK,
        PH_RISE,
        PH_FALL
    } phase_t;

    typedef struct packed {
        logic restart;
        logic step;
    } swing_ctrl_t;

    typedef struct packed {
        logic   found;
        lag_t   lag;
        price_t value;
    } swing_res_t;

endpackage

`default_nettype wire

[hw/rtl/swing_peak_trough_detector.sv]
// Top level of the swing peak / trough detector: bar input stage, two swing machines, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  bar      | bar_valid / bar_ready     | bar_high, bar_low, series_start
//  swing    | swing_valid / swing_ready | peak_found/lag/value, trough_found/lag/value
//
// One bar per cycle sustained while the result is not stalled; a taken bar is held in
// the input register, which feeds the machines and their compares into the result register.
// Reset leaves both machines awaiting a first bar, which only primes them.
// A stalled result holds the result register; the input register still takes one bar.
`default_nettype none

module swing_peak_trough_detector
    import stp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   bar_valid,
    output logic        bar_ready,
    input  wire price_t bar_high,
    input  wire price_t bar_low,
    input  wire logic   series_start,
    output logic        swing_valid,
    input  wire logic   swing_ready,
    output logic        peak_found,
    output lag_t        peak_lag,
    output price_t      peak_value,
    output logic        trough_found,
    output lag_t        trough_lag,
    output price_t      trough_value
);

    logic   s1_valid_reg, s1_valid_next;
    price_t s1_high_reg;
    price_t s1_low_reg;
    logic   s1_start_reg;
    price_t last_high_reg;
    price_t last_low_reg;

    logic   out_valid_reg, out_valid_next;
    logic   peak_found_reg;
    lag_t   peak_lag_reg;
    price_t peak_value_reg;
    logic   trough_found_reg;
    lag_t   trough_lag_reg;
    price_t trough_value_reg;

    logic        advance;
    logic        take;
    logic        primed_hi;
    logic        primed_lo;
    logic        prime;
    swing_ctrl_t ctrl;
    swing_res_t  res_hi;
    swing_res_t  res_lo;

    assign advance   = s1_valid_reg && (!out_valid_reg || swing_ready);
    assign bar_ready = !s1_valid_reg || advance;
    assign take      = bar_valid && bar_ready;

    assign prime = s1_start_reg || primed_hi || primed_lo;
    assign ctrl  = '{restart: advance && prime, step: advance && !prime};

    stp_swing u_high (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .prev   (last_high_reg),
        .cur    (s1_high_reg),
        .res    (res_hi),
        .primed (primed_hi)
    );

    // trough side runs on inverted lows
    stp_swing u_low (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .prev   (~last_low_reg),
        .cur    (~s1_low_reg),
        .res    (res_lo),
        .primed (primed_lo)
    );

    assign s1_valid_next  = take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !swing_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_high_reg <= '0;
            last_low_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_high_reg <= s1_high_reg;
                last_low_reg  <= s1_low_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_high_reg  <= bar_high;
            s1_low_reg   <= bar_low;
            s1_start_reg <= series_start;
        end
        if (advance)
        begin
            peak_found_reg   <= res_hi.found;
            peak_lag_reg     <= res_hi.lag;
            peak_value_reg   <= res_hi.value;
            trough_found_reg <= res_lo.found;
            trough_lag_reg   <= res_lo.lag;
            trough_value_reg <= res_lo.found ? ~res_lo.value : '0;
        end
    end

    assign swing_valid  = out_valid_reg;
    assign peak_found   = peak_found_reg;
    assign peak_lag     = peak_lag_reg;
    assign peak_value   = peak_value_reg;
    assign trough_found = trough_found_reg;
    assign trough_lag   = trough_lag_reg;
    assign trough_value = trough_value_reg;

endmodule

`default_nettype wire

[hw/rtl/stp_swing.sv]
// One swing machine that confirms peaks; the trough side feeds it inverted prices.
`default_nettype none

module stp_swing
    import stp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire swing_ctrl_t ctrl,
    input  wire price_t      prev,
    input  wire price_t      cur,
    output swing_res_t       res,
    output logic             primed
);

    phase_t phase_reg, phase_next;
    price_t ref_reg, ref_next;
    price_t cand_reg, cand_next;
    lag_t   age_reg, age_next;

    price_t pair_max;
    lag_t   age_inc;
    logic   cur_gt_ref;
    logic   cur_lt_cand;
    logic   cur_gt_cand;

    assign pair_max    = (cur > prev) ? cur : prev;
    assign age_inc     = (age_reg == {LAG_BITS{1'b1}}) ? age_reg : age_reg + lag_t'(1);
    assign cur_gt_ref  = cur > ref_reg;
    assign cur_lt_cand = cur < cand_reg;
    assign cur_gt_cand = cur > cand_reg;
    assign primed      = (phase_reg == PH_PRIME);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.restart)
        begin
            phase_next = PH_START;
        end
        else if (ctrl.step)
        begin
            case (phase_reg)
                PH_START: phase_next = PH_SEEK;
                PH_SEEK:  phase_next = cur_gt_ref ? PH_RISE : PH_SEEK;
                PH_RISE:  phase_next = cur_lt_cand ? PH_FALL : PH_RISE;
                PH_FALL:  phase_next = cur_lt_cand ? PH_SEEK : PH_RISE;
                default:  phase_next = PH_START;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        ref_next  = ref_reg;
        cand_next = cand_reg;
        age_next  = age_reg;
        res       = '0;
        if (ctrl.step && !ctrl.restart)
        begin
            age_next = age_inc;
            case (phase_reg)
                PH_START:
                begin
                    ref_next  = pair_max;
                    cand_next = '0;
                    age_next  = '0;
                end
                PH_SEEK:
                begin
                    if (cur_gt_ref)
                    begin
                        cand_next = cur;
                        age_next  = '0;
                    end
                    else
                    begin
                        ref_next = pair_max;
                    end
                end
                PH_RISE:
                begin
                    if (!cur_lt_cand)
                    begin
                        cand_next = cur;
                        age_next  = '0;
                    end
                end
                PH_FALL:
                begin
                    if (cur_lt_cand)
                    begin
                        ref_next  = pair_max;
                        res.found = 1'b1;
                        res.lag   = age_inc;
                        res.value = cand_reg;
                    end
                    else if (cur_gt_cand)
                    begin
                        cand_next = cur;
                        age_next  = '0;
                    end
                end
                default:
                begin
                    age_next = age_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRIME;
            ref_reg   <= '0;
            cand_reg  <= '0;
            age_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ref_reg   <= ref_next;
            cand_reg  <= cand_next;
            age_reg   <= age_next;
        end
    end

endmodule

`default_nettype wire

[tb/swing_checker.sv]
// Checker for the swing detector: watches both channels, predicts each result beat and compares.
`timescale 1ns / 100ps

module swing_checker
    import stp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   bar_valid,
    input  wire logic   bar_ready,
    input  wire price_t bar_high,
    input  wire price_t bar_low,
    input  wire logic   series_start,
    input  wire logic   swing_valid,
    input  wire logic   swing_ready,
    input  wire logic   peak_found,
    input  wire lag_t   peak_lag,
    input  wire price_t peak_value,
    input  wire logic   trough_found,
    input  wire lag_t   trough_lag,
    input  wire price_t trough_value,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        phase_t phase;
        price_t anchor;
        price_t cand;
        lag_t   age;
    } swing_track_t;

    typedef struct packed {
        swing_res_t peak;
        swing_res_t trough;
    } swing_pair_t;

    // trough tracker runs on inverted lows
    swing_track_t peak_trk;
    swing_track_t trough_trk;
    price_t       prev_high;
    price_t       prev_low;
    swing_pair_t  swing_q[$];
    int           errs = 0;

    function automatic swing_track_t track_swing(swing_track_t t, price_t prev, price_t cur);
        price_t pair_max;
        pair_max = (cur > prev) ? cur : prev;
        t.age = (t.age == '1) ? t.age : t.age + 1'b1;
        case (t.phase)
            PH_START:
            begin
                t.anchor = pair_max;
                t.cand   = '0;
                t.age    = '0;
                t.phase  = PH_SEEK;
            end
            PH_SEEK:
                if (cur > t.anchor)
                begin
                    t.cand  = cur;
                    t.age   = '0;
                    t.phase = PH_RISE;
                end
                else
                    t.anchor = pair_max;
            PH_RISE:
                if (cur < t.cand)
                    t.phase = PH_FALL;
                else
                begin
                    t.cand = cur;
                    t.age  = '0;
                end
            PH_FALL:
                if (cur < t.cand)
                begin
                    t.anchor = pair_max;
                    t.phase  = PH_SEEK;
                end
                else if (cur > t.cand)
                begin
                    t.cand  = cur;
                    t.age   = '0;
                    t.phase = PH_RISE;
                end
                else
                    t.phase = PH_RISE;
            default:
                t.phase = PH_START;
        endcase
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        swing_pair_t want;
        swing_pair_t got;
        logic        peak_hit;
        logic        trough_hit;
        if (!rst_n)
        begin
            peak_trk   = '{PH_PRIME, '0, '0, '0};
            trough_trk = '{PH_PRIME, '0, '0, '0};
            prev_high  = '0;
            prev_low   = '0;
            swing_q.delete();
        end
        else
        begin
            if (swing_valid && swing_ready)
            begin
                got.peak.found   = peak_found;
                got.peak.lag     = peak_lag;
                got.peak.value   = peak_value;
                got.trough.found = trough_found;
                got.trough.lag   = trough_lag;
                got.trough.value = trough_value;
                if (swing_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result beat with nothing pending", $time);
                end
                else
                begin
                    want = swing_q.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t: peak exp %0b/%0d/%0h act %0b/%0d/%0h", $time,
                                     want.peak.found, want.peak.lag, want.peak.value,
                                     got.peak.found, got.peak.lag, got.peak.value);
                            $display("%0t: trough exp %0b/%0d/%0h act %0b/%0d/%0h", $time,
                                     want.trough.found, want.trough.lag, want.trough.value,
                                     got.trough.found, got.trough.lag, got.trough.value);
                        end
                    end
                end
            end

            if (bar_valid && bar_ready)
            begin
                want = '0;
                if (series_start || peak_trk.phase == PH_PRIME || trough_trk.phase == PH_PRIME)
                begin
                    peak_trk.phase   = PH_START;
                    trough_trk.phase = PH_START;
                end
                else
                begin
                    peak_hit   = (peak_trk.phase == PH_FALL) && (bar_high < peak_trk.cand);
                    trough_hit = (trough_trk.phase == PH_FALL) && (~bar_low < trough_trk.cand);
                    peak_trk   = track_swing(peak_trk, prev_high, bar_high);
                    trough_trk = track_swing(trough_trk, ~prev_low, ~bar_low);
                    if (peak_hit)
                    begin
                        want.peak.found = 1'b1;
                        want.peak.lag   = peak_trk.age;
                        want.peak.value = peak_trk.cand;
                    end
                    if (trough_hit)
                    begin
                        want.trough.found = 1'b1;
                        want.trough.lag   = trough_trk.age;
                        want.trough.value = ~trough_trk.cand;
                    end
                end
                prev_high = bar_high;
                prev_low  = bar_low;
                swing_q.push_back(want);
            end
        end
        mismatches  <= errs;
        outstanding <= swing_q.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the swing detector: clock, reset, bar stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module tb_top
    import stp_pkg::*;
;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   bar_valid    = 1'b0;
    logic   bar_ready;
    price_t bar_high     = '0;
    price_t bar_low      = '0;
    logic   series_start = 1'b0;
    logic   swing_valid;
    logic   swing_ready  = 1'b0;
    logic   peak_found;
    lag_t   peak_lag;
    price_t peak_value;
    logic   trough_found;
    lag_t   trough_lag;
    price_t trough_value;
    int     mismatches;
    int     outstanding;
    logic   idle_on      = 1'b1;
    int     stall_left   = 0;
    int     bars_sent    = 0;

    swing_peak_trough_detector i_dut (.*);

    swing_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left  <= stall_left - 1;
            swing_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left  <= $urandom_range(1, 14) - 1;
            swing_ready <= 1'b0;
        end
        else
            swing_ready <= 1'b1;
    end

    task automatic send_bar(input price_t h, input price_t l, input logic restart);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            bar_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bar_valid    <= 1'b1;
        bar_high     <= h;
        bar_low      <= l;
        series_start <= restart;
        do
            @(posedge clk);
        while (!bar_ready);
        bars_sent++;
    endtask

    // random walk with noise, flat bars and restarts mixed in
    task automatic run_series(input int bars);
        price_t h;
        price_t l;
        int     mode;
        h = $urandom;
        l = h - $urandom_range(0, 8);
        send_bar(h, l, 1'b1);
        for (int k = 1; k < bars; k++)
        begin
            mode = $urandom_range(0, 39);
            if (mode < 2)
            begin
                h = $urandom;
                l = $urandom;
            end
            else if (mode < 4)
            begin
                h = $urandom_range(0, 1) ? '1 : '0;
                l = $urandom_range(0, 1) ? '1 : '0;
            end
            else
            begin
                h = h + $urandom_range(0, 4) - 2;
                l = l + $urandom_range(0, 4) - 2;
            end
            send_bar(h, l, mode == 4);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // first bar after reset primes without a restart flag; extremes and flat bars
        send_bar('0, '0, 1'b0);
        send_bar('0, '1, 1'b0);
        send_bar('1, '0, 1'b0);
        send_bar(32'hFFFF_FFFE, 32'h1, 1'b0);
        send_bar('1, '0, 1'b0);
        send_bar(32'hFFFF_FFFE, 32'h1, 1'b0);
        send_bar(32'hFFFF_FFFD, 32'h2, 1'b0);
        send_bar(32'd10, 32'd20, 1'b1);
        send_bar(32'd10, 32'd20, 1'b0);
        send_bar(32'd30, 32'd5, 1'b0);
        send_bar(32'd30, 32'd5, 1'b0);
        send_bar(32'd25, 32'd8, 1'b0);
        send_bar(32'd31, 32'd4, 1'b0);
        send_bar(32'd29, 32'd6, 1'b0);
        send_bar(32'd28, 32'd7, 1'b0);
        send_bar(32'd40, 32'd1, 1'b0);
        send_bar(32'd40, 32'd1, 1'b0);
        send_bar(32'd39, 32'd2, 1'b0);
        send_bar(32'd39, 32'd2, 1'b0);
        send_bar('0, '1, 1'b0);
        send_bar('1, '0, 1'b0);
        send_bar('1, '0, 1'b0);

        // lower/equal pairs keep both candidates alive while their ages grow
        idle_on <= 1'b0;
        send_bar(32'd100, 32'd100, 1'b1);
        send_bar(32'd100, 32'd100, 1'b0);
        send_bar(32'd200, 32'd50, 1'b0);
        for (int k = 0; k < 100; k++)
        begin
            send_bar(32'd199, 32'd51, 1'b0);
            send_bar(32'd200, 32'd50, 1'b0);
        end
        send_bar(32'd199, 32'd51, 1'b0);
        send_bar(32'd198, 32'd52, 1'b0);
        idle_on <= 1'b1;

        bars_sent = 0;
        while (bars_sent < 1250)
        begin
            if (bars_sent > 1100)
                idle_on <= 1'b0;
            run_series($urandom_range(4, 40));
        end

        bar_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
